>>> rtl/lrbd_pkg.sv
// Shared constants, widths and types of the label region boundary detector.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lrbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LABEL_BITS = 24;
  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_HEIGHT);
  localparam int DIM_BITS   = 13;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  typedef logic [X_BITS-1:0]     col_t;
  typedef logic [Y_BITS-1:0]     row_t;
  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [LABEL_BITS-1:0] label_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TARGET_LABEL = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_t;

  // Read request to the line stores: column of the arriving pixel.
  typedef struct packed {
    logic en;
    col_t addr;
  } lrbd_rd_req_t;

  // One-bit write into a line store.
  typedef struct packed {
    logic en;
    col_t addr;
    logic data;
  } lrbd_wr_t;

  // Registered read data: match bits above, above-right and two rows up.
  typedef struct packed {
    logic above;
    logic right;
    logic up2;
  } lrbd_rd_t;

endpackage

>>> rtl/lrbd_if.sv
// Handshake channel interfaces of the label region boundary detector.
// Depends on lrbd_pkg for payload widths.
interface lrbd_in_if;
  logic                 valid;
  logic                 ready;
  lrbd_pkg::label_t     pixel_label;
  logic                 frame_start;

  modport source (output valid, output pixel_label, output frame_start, input ready);
  modport sink   (input valid, input pixel_label, input frame_start, output ready);
endinterface

interface lrbd_out_if;
  logic                 valid;
  logic                 ready;
  lrbd_pkg::col_t       edge_x;
  lrbd_pkg::row_t       edge_y;
  logic                 last_in_run;

  modport source (output valid, output edge_x, output edge_y, output last_in_run,
                  input ready);
  modport sink   (input valid, input edge_x, input edge_y, input last_in_run,
                  output ready);
endinterface

interface lrbd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lrbd_pkg::CFG_IDX_BITS-1:0]    index;
  logic [lrbd_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lrbd_line_store.sv
// Two one-bit line stores (previous row and older row match bits) with a
// clearing sweep after reset. Depends on lrbd_pkg.
module lrbd_line_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrbd_pkg::lrbd_rd_req_t rd_req,
  input  lrbd_pkg::lrbd_wr_t     prev_wr,
  input  lrbd_pkg::lrbd_wr_t     older_wr,
  output lrbd_pkg::lrbd_rd_t     rd_data,
  output logic                   clr_busy
);

  logic prev_mem  [lrbd_pkg::MAX_WIDTH];
  logic older_mem [lrbd_pkg::MAX_WIDTH];

  logic           clr_busy_r, clr_busy_nxt;
  lrbd_pkg::col_t clr_addr_r, clr_addr_nxt;
  lrbd_pkg::col_t right_addr;
  logic           above_r, right_r, up2_r;

  assign right_addr = lrbd_pkg::col_t'(rd_req.addr + 1'b1);

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = lrbd_pkg::col_t'(clr_addr_r + 1'b1);
      if (clr_addr_r == lrbd_pkg::col_t'(lrbd_pkg::MAX_WIDTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Write ports: the sweep owns both stores until it is done.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      prev_mem[clr_addr_r]  <= 1'b0;
      older_mem[clr_addr_r] <= 1'b0;
    end else begin
      if (prev_wr.en) begin
        prev_mem[prev_wr.addr] <= prev_wr.data;
      end
      if (older_wr.en) begin
        older_mem[older_wr.addr] <= older_wr.data;
      end
    end
  end

  // Read ports return the contents from before a same-cycle write.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      above_r <= prev_mem[rd_req.addr];
      right_r <= prev_mem[right_addr];
      up2_r   <= older_mem[rd_req.addr];
    end
  end

  assign rd_data.above = above_r;
  assign rd_data.right = right_r;
  assign rd_data.up2   = up2_r;
  assign clr_busy      = clr_busy_r;

endmodule

>>> rtl/label_region_boundary_detect.sv
// Boundary pixel detector for one labeled region; a request passes the decision stage and
// then the result register. One request per cycle unless the output stalls; a request
// that causes two points holds the input until its second point is loaded. After reset
// the line stores are swept to zero with in_ready low. Configuration writes are taken
// at any time (cfg_ready is always high). Depends on lrbd_pkg, lrbd_if, lrbd_line_store.
module label_region_boundary_detect (
  input  logic        clk,
  input  logic        rst_n,
  lrbd_cfg_if.sink    cfg_ch,
  lrbd_in_if.sink     in_ch,
  lrbd_out_if.source  out_ch
);

  // Configuration registers.
  lrbd_pkg::label_t target_r;
  lrbd_pkg::dim_t   width_r;
  lrbd_pkg::dim_t   height_r;

  // Clamped frame dimensions: zero counts as one, oversize counts as the maximum.
  lrbd_pkg::dim_t w_cl, h_cl;

  // Raster position of the next request.
  lrbd_pkg::col_t cc_r, cc_nxt;
  lrbd_pkg::row_t rc_r, rc_nxt;

  // Position decode of the arriving request.
  lrbd_pkg::col_t cc0, acc_x;
  lrbd_pkg::row_t rc0, acc_y;
  lrbd_pkg::dim_t rc1, x1, y1;
  logic           col_wrap, row_end, acc_cur;

  // Decision stage: one request with its line store reads.
  logic           s1_v_r, s1_sent_r;
  lrbd_pkg::col_t s1_x_r;
  lrbd_pkg::row_t s1_y_r;
  logic           s1_cur_r, s1_yge1_r, s1_y1_r, s1_xedge_r, s1_lastrow_r;
  logic           left_r, byp_r, byp_val_r;
  logic           up2, p_above, p_here, pend_above, pend, emit_last, retire;

  // Result register.
  logic           out_v_r;
  lrbd_pkg::col_t out_x_r;
  lrbd_pkg::row_t out_y_r;
  logic           out_last_r;
  logic           out_load;

  logic                   in_acc, in_ready, clr_busy;
  lrbd_pkg::lrbd_rd_req_t rd_req;
  lrbd_pkg::lrbd_wr_t     prev_wr, older_wr;
  lrbd_pkg::lrbd_rd_t     rd_data;

  //--------------------------------------------------------------------------
  // Configuration port. The block assumes writes only arrive while idle.
  //--------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      width_r  <= lrbd_pkg::dim_t'(1024);
      height_r <= lrbd_pkg::dim_t'(1024);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lrbd_pkg::CFG_TARGET_LABEL: target_r <= cfg_ch.data[lrbd_pkg::LABEL_BITS-1:0];
        lrbd_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_ch.data[lrbd_pkg::DIM_BITS-1:0];
        lrbd_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_ch.data[lrbd_pkg::DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_cl = lrbd_pkg::dim_t'(1);
    end else if (width_r > lrbd_pkg::dim_t'(lrbd_pkg::MAX_WIDTH)) begin
      w_cl = lrbd_pkg::dim_t'(lrbd_pkg::MAX_WIDTH);
    end else begin
      w_cl = width_r;
    end
    if (height_r == '0) begin
      h_cl = lrbd_pkg::dim_t'(1);
    end else if (height_r > lrbd_pkg::dim_t'(lrbd_pkg::MAX_HEIGHT)) begin
      h_cl = lrbd_pkg::dim_t'(lrbd_pkg::MAX_HEIGHT);
    end else begin
      h_cl = height_r;
    end
  end

  //--------------------------------------------------------------------------
  // Position of the arriving request. A frame start restarts the counters, and
  // a count left beyond a frame that has shrunk wraps before it is used.
  //--------------------------------------------------------------------------
  always_comb begin
    cc0      = in_ch.frame_start ? '0 : cc_r;
    rc0      = in_ch.frame_start ? '0 : rc_r;
    col_wrap = {1'b0, cc0} >= w_cl;
    acc_x    = col_wrap ? '0 : cc0;
    rc1      = col_wrap ? lrbd_pkg::dim_t'({1'b0, rc0} + 1'b1) : {1'b0, rc0};
    acc_y    = (rc1 >= h_cl) ? '0 : rc1[lrbd_pkg::Y_BITS-1:0];
    x1       = lrbd_pkg::dim_t'({1'b0, acc_x} + 1'b1);
    y1       = lrbd_pkg::dim_t'({1'b0, acc_y} + 1'b1);
    row_end  = x1 >= w_cl;
    if (row_end) begin
      cc_nxt = '0;
      rc_nxt = (y1 >= h_cl) ? '0 : y1[lrbd_pkg::Y_BITS-1:0];
    end else begin
      cc_nxt = x1[lrbd_pkg::X_BITS-1:0];
      rc_nxt = acc_y;
    end
  end

  // A target of zero selects nothing.
  assign acc_cur = (target_r != '0) && (in_ch.pixel_label == target_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      rc_r <= '0;
    end else if (in_acc) begin
      cc_r <= cc_nxt;
      rc_r <= rc_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // Line stores. On a request the stores are read at the request's column
  // (previous row here and one to the right, older row here), and the current
  // match bit goes into the previous-row store in the same cycle; the read
  // returns the value from before that write. The older-row store takes the
  // bit read from the previous-row store while the request sits in the
  // decision stage.
  //--------------------------------------------------------------------------
  assign rd_req.en    = in_acc;
  assign rd_req.addr  = acc_x;
  assign prev_wr.en   = in_acc;
  assign prev_wr.addr = acc_x;
  assign prev_wr.data = acc_cur;
  assign older_wr.en   = s1_v_r;
  assign older_wr.addr = s1_x_r;
  assign older_wr.data = rd_data.above;

  lrbd_line_store u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_req   (rd_req),
    .prev_wr  (prev_wr),
    .older_wr (older_wr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  //--------------------------------------------------------------------------
  // Decision stage. The pixel one row above the request is decided here. Its
  // left neighbor is the previous request's above bit: a request at a nonzero
  // column always follows the request one column to the left in the same row.
  // When the older-row write of the request still in this stage hits the same
  // column as the new read, the read is stale and the bit is bypassed.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r       <= acc_x;
      s1_y_r       <= acc_y;
      s1_cur_r     <= acc_cur;
      s1_yge1_r    <= acc_y != '0;
      s1_y1_r      <= acc_y == lrbd_pkg::row_t'(1);
      s1_xedge_r   <= (acc_x == '0) ||
                      ({1'b0, acc_x} == lrbd_pkg::dim_t'(w_cl - 1'b1));
      s1_lastrow_r <= {1'b0, acc_y} == lrbd_pkg::dim_t'(h_cl - 1'b1);
      left_r       <= rd_data.above;
      byp_r        <= s1_v_r && (s1_x_r == acc_x);
      byp_val_r    <= rd_data.above;
    end
  end

  assign up2 = byp_r ? byp_val_r : rd_data.up2;

  // Point above: the pixel above matched and lies on the frame border or has
  // a neighbor that does not match. Point here: a matching pixel of the last row.
  assign p_above = s1_yge1_r && rd_data.above &&
                   (s1_xedge_r || s1_y1_r || !left_r || !rd_data.right || !up2 || !s1_cur_r);
  assign p_here  = s1_lastrow_r && s1_cur_r;

  assign pend_above = p_above && !s1_sent_r;
  assign pend       = pend_above || p_here;
  assign emit_last  = !pend_above || !p_here;
  assign out_load   = !out_v_r || out_ch.ready;
  assign retire     = s1_v_r && (!pend || (out_load && emit_last));

  assign in_ready = !clr_busy && (!s1_v_r || retire);
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_sent_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (retire) begin
        s1_v_r <= 1'b0;
      end
      if (in_acc || retire) begin
        s1_sent_r <= 1'b0;
      end else if (s1_v_r && pend && out_load && !emit_last) begin
        s1_sent_r <= 1'b1;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Result register: the point above goes out first, then the last-row point.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r && pend;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= s1_x_r;
      out_y_r    <= pend_above ? lrbd_pkg::row_t'(s1_y_r - 1'b1) : s1_y_r;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.edge_x      = out_x_r;
  assign out_ch.edge_y      = out_y_r;
  assign out_ch.last_in_run = out_last_r;

  //--------------------------------------------------------------------------
  // Assertions.
  //--------------------------------------------------------------------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_acc)
    else $error("request accepted during line store sweep");

  a_left_neighbor_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && acc_x != '0) |-> (acc_x == lrbd_pkg::col_t'(s1_x_r + 1'b1)))
    else $error("request at nonzero column does not follow its left neighbor");

  a_sent_only_for_two_points: assert property (@(posedge clk) disable iff (!rst_n)
    s1_sent_r |-> (s1_v_r && p_above && p_here))
    else $error("first point marked sent without a second point pending");

  a_result_column_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ({1'b0, out_x_r} < w_cl))
    else $error("result column outside the frame width");

endmodule
